// ===== rtl/fdr_pkg.sv =====
// Shared constants and the window normalization table for the feature delta regression block.
package fdr_pkg;

  localparam int DEF_MAX_WINDOW   = 8;
  localparam int DEF_MAX_FEATURES = 64;
  localparam int DEF_SAMPLE_BITS  = 16;

  localparam int CFG_DATA_BITS = 7;
  localparam int CFG_W_BITS    = 4;
  localparam int CFG_F_BITS    = 7;
  localparam int IDX_BITS      = 6;
  localparam int DEN_BITS      = 12;
  localparam int WIN_ARG_BITS  = 5;

  localparam logic [CFG_W_BITS-1:0] WINDOW_RESET   = 4'd2;
  localparam logic [CFG_F_BITS-1:0] FEATURES_RESET = 7'd13;

  localparam logic [0:0] CFG_WINDOW   = 1'b0;
  localparam logic [0:0] CFG_FEATURES = 1'b1;

  // 2 * sum of n*n for n = 1..w
  function automatic logic [DEN_BITS-1:0] den_of(input logic [WIN_ARG_BITS-1:0] w);
    logic [DEN_BITS-1:0] d;
    case (w)
      5'd1:    d = 12'd2;
      5'd2:    d = 12'd10;
      5'd3:    d = 12'd28;
      5'd4:    d = 12'd60;
      5'd5:    d = 12'd110;
      5'd6:    d = 12'd182;
      5'd7:    d = 12'd280;
      5'd8:    d = 12'd408;
      5'd9:    d = 12'd570;
      5'd10:   d = 12'd770;
      5'd11:   d = 12'd1012;
      5'd12:   d = 12'd1300;
      5'd13:   d = 12'd1638;
      5'd14:   d = 12'd2030;
      5'd15:   d = 12'd2480;
      5'd16:   d = 12'd2992;
      default: d = 12'd2;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/fdr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module fdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1088
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fdr_div.sv =====
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module fdr_div import fdr_pkg::*; #(
  parameter int NUM_BITS = 23,
  parameter int Q_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0]        divisor,
  output logic                       busy,
  output logic                       done,
  output logic signed [Q_BITS:0]     quotient
);

  localparam int DSH_BITS = DEN_BITS + Q_BITS;
  localparam int CMP_BITS = (NUM_BITS > DSH_BITS) ? NUM_BITS : DSH_BITS;
  localparam int CNT_BITS = $clog2(Q_BITS);

  logic [NUM_BITS-1:0] rem;
  logic [DSH_BITS-1:0] dsh;
  logic [Q_BITS-1:0]   qmag;
  logic [CNT_BITS-1:0] cnt;
  logic                neg;
  logic                fits;
  logic [NUM_BITS-1:0] mag_in;

  assign mag_in = dividend[NUM_BITS-1] ? NUM_BITS'(-dividend) : NUM_BITS'(dividend);
  assign fits   = CMP_BITS'(rem) >= CMP_BITS'(dsh);
  assign quotient = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // done rises together with the last quotient bit
      done <= !start && busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        rem  <= mag_in;
        neg  <= dividend[NUM_BITS-1];
        dsh  <= DSH_BITS'(divisor) << (Q_BITS - 1);
        cnt  <= CNT_BITS'(Q_BITS - 1);
        qmag <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - NUM_BITS'(dsh);
        end
        qmag <= {qmag[Q_BITS-2:0], fits};
        dsh  <= dsh >> 1;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/feature_delta_regression.sv =====
// Top level: streaming delta-regression of feature frames with a circular frame history.
//
// Feature values enter on the s_ channel one transfer at a time, frame by frame, in feature
// order; s_tuser[0] marks a real value (0 = padding, stored as zero) and s_tuser[1] marks the
// first value of a new sequence. Each accepted value, once W frames of the sequence are
// complete, yields one delta on the m_ channel for the same feature of the frame W behind;
// m_tlast marks the last feature of that frame. Append W padding frames to flush a sequence.
// Window W and feature count are set through cfg_we/cfg_index/cfg_data; the user must write
// them only while the block idles, as the block itself does not enforce this.
// Steps per value: accept and store it, then 2*W history reads through the one read port
// of the history RAM feeding a shared multiply-accumulate, a drain step, the bit-serial
// divider (one step per quotient bit, SAMPLE_BITS in general, plus its done flag) and
// loading the output register. A value that gives no delta (warm-up) is only accepted and
// stored. s_tready is high only while the sequencer is idle.
// The output register holds a delta while m_tready is low; the next value is still accepted
// and worked on, and it waits in its last step until the register is free.
// Reset (rst, synchronous) clears the counters, the history head and the registers to their
// defaults; the history RAM is not cleared, stale slots are masked by the frame count.
module feature_delta_regression import fdr_pkg::*; #(
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
  parameter int MAX_FEATURES = DEF_MAX_FEATURES,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [0:0]                                cfg_index,
  input  logic [CFG_DATA_BITS-1:0]                  cfg_data,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // feature_value
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]          s_tdata,
  // is_real_frame, sequence_start
  input  logic [1:0]                                s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // delta_value, feature_index
  output logic [((SAMPLE_BITS+IDX_BITS+7)/8)*8-1:0] m_tdata,
  output logic                                      m_tlast
);

  localparam int HIST_FRAMES = 2 * MAX_WINDOW + 1;
  localparam int HEAD_BITS   = $clog2(HIST_FRAMES);
  localparam int SEEN_BITS   = $clog2(HIST_FRAMES + 1);
  localparam int COL_BITS    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int FE_BITS     = $clog2(MAX_FEATURES + 1);
  localparam int W_BITS      = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_BITS   = HEAD_BITS + COL_BITS;
  localparam int RAM_DEPTH   = HIST_FRAMES * (1 << COL_BITS);
  localparam int SUM_N_MAX   = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
  localparam int NUM_BITS    = SAMPLE_BITS + 1 + $clog2(SUM_N_MAX + 1);
  localparam int PROD_BITS   = SAMPLE_BITS + W_BITS + 1;
  localparam int OUT_BITS    = ((SAMPLE_BITS + IDX_BITS + 7) / 8) * 8;
  localparam int PAD_BITS    = OUT_BITS - SAMPLE_BITS - IDX_BITS;

  typedef enum logic [2:0] {IDLE, READ, DRAIN, DIV, FINISH} state_t;

  state_t state;

  logic [CFG_W_BITS-1:0] window_size;
  logic [CFG_F_BITS-1:0] feature_count;

  logic [SEEN_BITS-1:0] frames_seen;
  logic [COL_BITS-1:0]  feature_position;
  logic [HEAD_BITS-1:0] history_head;

  // per-item context
  logic [W_BITS-1:0]    cur_w;
  logic [COL_BITS-1:0]  cur_col;
  logic                 cur_last;
  logic [SEEN_BITS-1:0] cur_seen;
  logic [HEAD_BITS-1:0] cur_head;

  // read sequencer and MAC tags for the RAM data of the next cycle
  logic [W_BITS-1:0] rd_n;
  logic              rd_behind;
  logic              tag_valid;
  logic [W_BITS-1:0] tag_n;
  logic              tag_sub;
  logic              tag_zero;

  logic signed [NUM_BITS-1:0]  acc;
  logic signed [NUM_BITS-1:0]  acc_next;
  logic signed [PROD_BITS-1:0] prod;

  logic [W_BITS-1:0]    w_eff;
  logic [FE_BITS-1:0]   f_eff;
  logic [SEEN_BITS-1:0] seen_in;
  logic [COL_BITS-1:0]  pos_in;
  logic                 last_in;
  logic                 produce_in;
  logic                 accept;

  logic [HEAD_BITS:0]     back;
  logic [HEAD_BITS:0]     slot_wide;
  logic                   mask_zero;
  logic [ADDR_BITS-1:0]   raddr;
  logic [ADDR_BITS-1:0]   waddr;
  logic [SAMPLE_BITS-1:0] wdata;
  logic [SAMPLE_BITS-1:0] rdata;

  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic signed [SAMPLE_BITS:0] div_q;
  logic [SAMPLE_BITS-1:0]   delta_sat;

  logic [SAMPLE_BITS-1:0] out_delta;
  logic [IDX_BITS-1:0]    out_index;
  logic                   out_free;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // clamped registers and the view of the counters after a sequence start
  always_comb begin
    if (window_size == '0) begin
      w_eff = W_BITS'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      w_eff = W_BITS'(MAX_WINDOW);
    end else begin
      w_eff = W_BITS'(window_size);
    end
    if (feature_count == '0) begin
      f_eff = FE_BITS'(1);
    end else if (int'(feature_count) > MAX_FEATURES) begin
      f_eff = FE_BITS'(MAX_FEATURES);
    end else begin
      f_eff = FE_BITS'(feature_count);
    end
    seen_in    = s_tuser[1] ? '0 : frames_seen;
    pos_in     = s_tuser[1] ? '0 : feature_position;
    last_in    = (int'(pos_in) + 1) >= int'(f_eff);
    produce_in = int'(seen_in) >= int'(w_eff);
  end

  assign wdata = s_tuser[0] ? s_tdata[SAMPLE_BITS-1:0] : '0;
  assign waddr = {history_head, pos_in};

  // history slot of the frame (w -/+ n) behind the current one
  always_comb begin
    if (rd_behind) begin
      back = (HEAD_BITS+1)'(cur_w) + (HEAD_BITS+1)'(rd_n);
    end else begin
      back = (HEAD_BITS+1)'(cur_w) - (HEAD_BITS+1)'(rd_n);
    end
    if ({1'b0, cur_head} >= back) begin
      slot_wide = {1'b0, cur_head} - back;
    end else begin
      slot_wide = {1'b0, cur_head} + (HEAD_BITS+1)'(HIST_FRAMES) - back;
    end
    mask_zero = rd_behind && (int'(cur_seen) < int'(cur_w) + int'(rd_n));
  end

  assign raddr = {slot_wide[HEAD_BITS-1:0], cur_col};

  // shared multiply-accumulate
  assign prod = $signed(rdata) * $signed({1'b0, tag_n});

  always_comb begin
    acc_next = acc;
    if (tag_valid && !tag_zero) begin
      if (tag_sub) begin
        acc_next = acc - NUM_BITS'(prod);
      end else begin
        acc_next = acc + NUM_BITS'(prod);
      end
    end
  end

  assign div_start = (state == DRAIN);

  // quotient stays below 2^(SAMPLE_BITS-1) in magnitude; clamp anyway
  always_comb begin
    if (!div_q[SAMPLE_BITS] && div_q[SAMPLE_BITS-1]) begin
      delta_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (div_q[SAMPLE_BITS] && !div_q[SAMPLE_BITS-1]) begin
      delta_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      delta_sat = div_q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= IDLE;
      window_size      <= WINDOW_RESET;
      feature_count    <= FEATURES_RESET;
      frames_seen      <= '0;
      feature_position <= '0;
      history_head     <= '0;
      tag_valid        <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW:   window_size   <= cfg_data[CFG_W_BITS-1:0];
          CFG_FEATURES: feature_count <= cfg_data[CFG_F_BITS-1:0];
          default: ;
        endcase
      end

      if (state == FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // accumulator is held clear while idle
      acc       <= (state == IDLE) ? '0 : acc_next;
      tag_valid <= (state == READ);

      case (state)
        IDLE: begin
          if (accept) begin
            cur_w     <= w_eff;
            cur_col   <= pos_in;
            cur_last  <= last_in;
            cur_seen  <= seen_in;
            cur_head  <= history_head;
            rd_n      <= W_BITS'(1);
            rd_behind <= 1'b0;
            if (last_in) begin
              feature_position <= '0;
              history_head     <= (int'(history_head) == HIST_FRAMES - 1) ? '0
                                  : history_head + 1'b1;
              if (int'(seen_in) < HIST_FRAMES) begin
                frames_seen <= seen_in + 1'b1;
              end else begin
                frames_seen <= seen_in;
              end
            end else begin
              feature_position <= pos_in + 1'b1;
              frames_seen      <= seen_in;
            end
            if (produce_in) begin
              state <= READ;
            end
          end
        end
        READ: begin
          tag_n     <= rd_n;
          tag_sub   <= rd_behind;
          tag_zero  <= mask_zero;
          rd_behind <= !rd_behind;
          if (rd_behind) begin
            if (rd_n == cur_w) begin
              state <= DRAIN;
            end else begin
              rd_n <= rd_n + 1'b1;
            end
          end
        end
        DRAIN: begin
          state <= DIV;
        end
        DIV: begin
          if (div_done) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            out_delta <= delta_sat;
            out_index <= IDX_BITS'(cur_col);
            m_tlast   <= cur_last;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tdata = {{PAD_BITS{1'b0}}, out_index, out_delta};

  fdr_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(RAM_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (accept),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  fdr_div #(
    .NUM_BITS(NUM_BITS),
    .Q_BITS  (SAMPLE_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc_next),
    .divisor (den_of(WIN_ARG_BITS'(cur_w))),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  // divider is never restarted while it is still iterating
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // MAC data only arrives right after a read was issued
  a_tag_in_read: assert property (@(posedge clk) disable iff (rst)
    tag_valid |-> (state == READ || state == DRAIN))
    else $error("history data outside read phase");

  // an item past warm-up starts the history walk
  a_accept_to_read: assert property (@(posedge clk) disable iff (rst)
    (accept && produce_in) |=> (state == READ && rd_n == W_BITS'(1) && !rd_behind))
    else $error("walk did not start after accepted item");

  // the walk index never passes the window
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == READ) |-> (rd_n != '0 && rd_n <= cur_w))
    else $error("walk index out of window");

endmodule
